// ===== sv/pwm_divider_wrap_calc_unit_macros.svh =====
// assertion macros for the pwm divider and wrap calculator
// included by files that check their own logic, no other dependencies
`ifndef PWM_DIVIDER_WRAP_CALC_UNIT_MACROS_SVH
`define PWM_DIVIDER_WRAP_CALC_UNIT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define PWMDW_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("pwmdw check failed");
`define PWMDW_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("pwmdw check failed");
`else
`define PWMDW_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define PWMDW_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

// ===== sv/pwmdw_pkg.sv =====
// shared constants and sideband types for the pwm divider and wrap calculator
// no dependencies
package pwmdw_pkg;

    localparam int CLK_W = 28;
    localparam int DIV_W = 12;
    localparam int WRAP_W = 17;
    localparam int FREQ_Q8_W = 30;
    localparam int WRAP_MAX_DEF = 65536;

    localparam logic [CLK_W-1:0] CLK_RESET = 28'd125000000;
    localparam logic [DIV_W-1:0] DIV_ONE = 12'd16;
    localparam logic [DIV_W-1:0] DIV_MAX = 12'd4095;
    localparam logic [WRAP_W-1:0] WRAP_MIN = 17'd100;

    typedef struct packed {
        logic [CLK_W-1:0] clk;
        logic [CLK_W-1:0] freq;
        logic             fits;
        logic             zero;
        logic             ovf;
    } t_s2_side;

    typedef struct packed {
        logic [CLK_W-1:0] clk;
        logic [DIV_W-1:0] div;
        logic             sat;
        logic             zero;
        logic             ovf;
    } t_s5_side;

    typedef struct packed {
        logic [DIV_W-1:0]  div;
        logic [WRAP_W-1:0] wrap;
        logic              sat;
    } t_s8_side;

endpackage

// ===== sv/pwmdw_divider.sv =====
// pipelined restoring divider, one quotient bit per stage, with sideband
// no dependencies; caller guarantees num < den << QW
module pwmdw_divider #(
    parameter int W  = 42,
    parameter int QW = 30,
    parameter int SW = 8
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_en,
    input  logic          i_valid,
    input  logic [W-1:0]  i_num,
    input  logic [W-1:0]  i_den,
    input  logic [SW-1:0] i_side,
    output logic          o_valid,
    output logic [QW-1:0] o_quo,
    output logic [SW-1:0] o_side
);

    localparam int XW = W + QW;

    logic [W-1:0]  r_rem  [QW+1];
    logic [W-1:0]  r_den  [QW+1];
    logic [QW-1:0] r_quo  [QW+1];
    logic [SW-1:0] r_side [QW+1];
    logic          r_vld  [QW+1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld[0] <= 1'b0;
        end else if (i_en) begin
            r_vld[0] <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem[0]  <= i_num;
            r_den[0]  <= i_den;
            r_quo[0]  <= '0;
            r_side[0] <= i_side;
        end
    end

    for (genvar k = 0; k < QW; k++) begin : g_stage
        localparam int B = QW - 1 - k;
        logic [XW-1:0] shifted;
        logic [XW-1:0] trial;
        logic          ge;
        logic [W-1:0]  n_rem;
        logic [QW-1:0] n_quo;

        always_comb begin
            shifted = XW'(r_den[k]) << B;
            ge      = XW'(r_rem[k]) >= shifted;
            trial   = XW'(r_rem[k]) - shifted;
            n_rem   = ge ? trial[W-1:0] : r_rem[k];
            n_quo   = r_quo[k];
            n_quo[B] = ge;
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[k+1] <= 1'b0;
            end else if (i_en) begin
                r_vld[k+1] <= r_vld[k];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[k+1]  <= n_rem;
                r_den[k+1]  <= r_den[k];
                r_quo[k+1]  <= n_quo;
                r_side[k+1] <= r_side[k];
            end
        end
    end

    assign o_valid = r_vld[QW];
    assign o_quo   = r_quo[QW];
    assign o_side  = r_side[QW];

endmodule

// ===== sv/pwm_divider_wrap_calc_unit.sv =====
// Takes one target frequency word per cycle when not stalled and returns the 8.4 divider,
// the wrap count, the realized frequency in Q8 Hz and a saturation flag.
// The pipeline is built from three bit-per-stage dividers (12, 17 and 30 quotient
// bits) plus the multiply and set-up stages around them. A stall on the output freezes
// the whole pipeline. Depends on pwmdw_pkg, pwmdw_divider and the macro header.
`include "pwm_divider_wrap_calc_unit_macros.svh"
module pwm_divider_wrap_calc_unit
    import pwmdw_pkg::*;
#(
    parameter int WRAP_MAX = WRAP_MAX_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CLK_W-1:0]     i_cfg_data,
    input  logic                 i_valid,
    output logic                 o_ready,
    input  logic [CLK_W-1:0]     i_target_freq_hz,
    output logic                 o_valid,
    input  logic                 i_ready,
    output logic [DIV_W-1:0]     o_divider_q4,
    output logic [WRAP_W-1:0]    o_wrap_count,
    output logic [FREQ_Q8_W-1:0] o_realized_freq_q8,
    output logic                 o_saturated
);

    localparam logic [WRAP_W-1:0] WMAX = WRAP_W'(WRAP_MAX);

    logic en;
    logic [CLK_W-1:0] r_input_clock_hz;

    // stage registers
    logic             r0_vld, r1_vld, r2_vld, r3_vld, r4_vld, r5_vld, r6_vld, r7_vld, r8_vld;
    logic [CLK_W-1:0] r0_clk, r0_freq, r1_clk, r1_freq;
    logic [44:0]      r1_fw;
    logic [45:0]      r2_num;
    logic [45:0]      r2_den;
    t_s2_side         r2_side;
    logic [CLK_W-1:0] r3_clk, r3_freq, r4_clk;
    logic [DIV_W-1:0] r3_div, r4_div;
    logic             r3_sat, r3_zero, r4_sat, r4_zero;
    logic [39:0]      r4_df;
    logic [40:0]      r5_num, r5_den;
    t_s5_side         r5_side;
    logic [CLK_W-1:0] r6_clk, r7_clk;
    logic [DIV_W-1:0] r6_div, r7_div;
    logic [WRAP_W-1:0] r6_wrap, r7_wrap;
    logic             r6_sat, r7_sat;
    logic [28:0]      r7_dw;
    logic [41:0]      r8_num, r8_den;
    t_s8_side         r8_side;

    // next values
    logic [44:0]       n1_fw;
    logic [45:0]       n2_num;
    t_s2_side          n2_side;
    logic [DIV_W-1:0]  n3_div;
    logic              n3_sat;
    logic [39:0]       n4_df;
    logic [40:0]       n5_num;
    t_s5_side          n5_side;
    logic [WRAP_W-1:0] n6_wrap;
    logic              n6_sat;
    logic [28:0]       n7_dw;

    // divider outputs
    logic             d1_vld, d2_vld, d3_vld;
    logic [11:0]      d1_quo;
    logic [16:0]      d2_quo;
    logic [29:0]      d3_quo;
    t_s2_side         d1_side;
    t_s5_side         d2_side;
    t_s8_side         d3_side;

    assign en      = !o_valid || i_ready;
    assign o_ready = en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_input_clock_hz <= CLK_RESET;
        end else if (i_cfg_we) begin
            r_input_clock_hz <= i_cfg_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r0_vld <= 1'b0;
            r1_vld <= 1'b0;
            r2_vld <= 1'b0;
            r3_vld <= 1'b0;
            r4_vld <= 1'b0;
            r5_vld <= 1'b0;
            r6_vld <= 1'b0;
            r7_vld <= 1'b0;
            r8_vld <= 1'b0;
        end else if (en) begin
            r0_vld <= i_valid;
            r1_vld <= r0_vld;
            r2_vld <= r1_vld;
            r3_vld <= d1_vld;
            r4_vld <= r3_vld;
            r5_vld <= r4_vld;
            r6_vld <= d2_vld;
            r7_vld <= r6_vld;
            r8_vld <= r7_vld;
        end
    end

    // target frequency times the maximum wrap count
    assign n1_fw = {17'b0, r0_freq} * {28'b0, WMAX};

    // ceil(16 * r1_clk / fw) set-up and overflow test
    always_comb begin
        n2_num       = {14'b0, r1_clk, 4'b0} + {1'b0, r1_fw} - 46'd1;
        n2_side.clk  = r1_clk;
        n2_side.freq = r1_freq;
        n2_side.fits = {17'b0, r1_clk} <= r1_fw;
        n2_side.zero = r1_freq == '0;
        n2_side.ovf  = {12'b0, n2_num} >= {1'b0, r1_fw, 12'b0};
    end

    always_comb begin
        n3_div = d1_quo;
        n3_sat = 1'b0;
        priority if (d1_side.zero) begin
            n3_div = DIV_MAX;
            n3_sat = 1'b1;
        end else if (d1_side.fits) begin
            n3_div = DIV_ONE;
        end else if (d1_side.ovf) begin
            n3_div = DIV_MAX;
            n3_sat = 1'b1;
        end
    end

    assign n4_df = {28'b0, r3_div} * {12'b0, r3_freq};

    // wrap = (32 * r4_clk + df) / (2 * df)
    always_comb begin
        n5_num       = {8'b0, r4_clk, 5'b0} + {1'b0, r4_df};
        n5_side.clk  = r4_clk;
        n5_side.div  = r4_div;
        n5_side.sat  = r4_sat;
        n5_side.zero = r4_zero;
        n5_side.ovf  = {17'b0, n5_num} >= {r4_df, 1'b0, 17'b0};
    end

    always_comb begin
        n6_wrap = d2_quo;
        n6_sat  = d2_side.sat;
        if (d2_side.zero || d2_side.ovf || d2_quo > WMAX) begin
            n6_wrap = WMAX;
            n6_sat  = 1'b1;
        end
        if (n6_wrap < WRAP_MIN) begin
            n6_wrap = WRAP_MIN;
        end
    end

    assign n7_dw = {17'b0, r6_div} * {12'b0, r6_wrap};

    always_ff @(posedge i_clk) begin
        if (en) begin
            r0_clk  <= r_input_clock_hz;
            r0_freq <= i_target_freq_hz;
            r1_clk  <= r0_clk;
            r1_freq <= r0_freq;
            r1_fw   <= n1_fw;
            r2_num  <= n2_num;
            r2_den  <= {1'b0, r1_fw};
            r2_side <= n2_side;
            r3_clk  <= d1_side.clk;
            r3_freq <= d1_side.freq;
            r3_div  <= n3_div;
            r3_sat  <= n3_sat;
            r3_zero <= d1_side.zero;
            r4_clk  <= r3_clk;
            r4_div  <= r3_div;
            r4_sat  <= r3_sat;
            r4_zero <= r3_zero;
            r4_df   <= n4_df;
            r5_num  <= n5_num;
            r5_den  <= {r4_df, 1'b0};
            r5_side <= n5_side;
            r6_clk  <= d2_side.clk;
            r6_div  <= d2_side.div;
            r6_wrap <= n6_wrap;
            r6_sat  <= n6_sat;
            r7_clk  <= r6_clk;
            r7_div  <= r6_div;
            r7_wrap <= r6_wrap;
            r7_sat  <= r6_sat;
            r7_dw   <= n7_dw;
            r8_num  <= {1'b0, r7_clk, 13'b0} + {13'b0, r7_dw};
            r8_den  <= {12'b0, r7_dw, 1'b0};
            r8_side <= '{div: r7_div, wrap: r7_wrap, sat: r7_sat};
        end
    end

    pwmdw_divider #(.W(46), .QW(12), .SW($bits(t_s2_side))) u_div_prescale (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (r2_vld),
        .i_num   (r2_num),
        .i_den   (r2_den),
        .i_side  (r2_side),
        .o_valid (d1_vld),
        .o_quo   (d1_quo),
        .o_side  (d1_side)
    );

    pwmdw_divider #(.W(41), .QW(17), .SW($bits(t_s5_side))) u_div_wrap (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (r5_vld),
        .i_num   (r5_num),
        .i_den   (r5_den),
        .i_side  (r5_side),
        .o_valid (d2_vld),
        .o_quo   (d2_quo),
        .o_side  (d2_side)
    );

    pwmdw_divider #(.W(42), .QW(30), .SW($bits(t_s8_side))) u_div_freq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (r8_vld),
        .i_num   (r8_num),
        .i_den   (r8_den),
        .i_side  (r8_side),
        .o_valid (d3_vld),
        .o_quo   (d3_quo),
        .o_side  (d3_side)
    );

    assign o_valid            = d3_vld;
    assign o_divider_q4       = d3_side.div;
    assign o_wrap_count       = d3_side.wrap;
    assign o_realized_freq_q8 = d3_quo;
    assign o_saturated        = d3_side.sat;

    `PWMDW_ASSERT_NEXT(a_accept_enters, i_clk, i_rst_n, i_valid && o_ready, r0_vld)
    `PWMDW_ASSERT_IMP(a_div_range, i_clk, i_rst_n, o_valid, o_divider_q4 >= DIV_ONE)
    `PWMDW_ASSERT_IMP(a_wrap_range, i_clk, i_rst_n, r6_vld,
        r6_wrap >= WRAP_MIN && r6_wrap <= WMAX)

endmodule

// ===== tb/pwm_divider_wrap_calc_unit_tb.sv =====
// testbench for pwm_divider_wrap_calc_unit: directed table then random words
// over several clock settings, each result checked against a typed value or
// an in-bench model; depends on pwmdw_pkg and the unit under test
`timescale 1ns / 1ps
module pwm_divider_wrap_calc_unit_tb;
    import pwmdw_pkg::*;

    localparam longint WMAX = WRAP_MAX_DEF;
    localparam int DRAIN = 90;
    localparam int STALL_LIMIT = 3000;
    localparam int N_ROWS = 18;

    typedef struct packed {
        logic [DIV_W-1:0]     div;
        logic [WRAP_W-1:0]    wrap;
        logic [FREQ_Q8_W-1:0] freq_q8;
        logic                 sat;
    } t_setting;

    typedef struct {
        logic [CLK_W-1:0] freq;
        bit               typed;
        t_setting         want;
    } t_row;

    logic                 i_clk = 0;
    logic                 i_rst_n = 0;
    logic                 i_cfg_we = 0;
    logic [CLK_W-1:0]     i_cfg_data = '0;
    logic                 i_valid = 0;
    logic                 o_ready;
    logic [CLK_W-1:0]     i_target_freq_hz = '0;
    logic                 o_valid;
    logic                 i_ready = 0;
    logic [DIV_W-1:0]     o_divider_q4;
    logic [WRAP_W-1:0]    o_wrap_count;
    logic [FREQ_Q8_W-1:0] o_realized_freq_q8;
    logic                 o_saturated;

    logic [CLK_W-1:0] clock_hz = CLK_RESET;
    t_setting         pending_q[$];
    int               errors = 0;
    int               idle_cycles = 0;
    bit               quiet = 0;

    pwm_divider_wrap_calc_unit uut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_we(i_cfg_we), .i_cfg_data(i_cfg_data),
        .i_valid(i_valid), .o_ready(o_ready), .i_target_freq_hz(i_target_freq_hz),
        .o_valid(o_valid), .i_ready(i_ready),
        .o_divider_q4(o_divider_q4), .o_wrap_count(o_wrap_count),
        .o_realized_freq_q8(o_realized_freq_q8), .o_saturated(o_saturated)
    );

    always #5 i_clk = ~i_clk;

    function automatic longint rnd_half_up(longint num, longint den);
        return (2 * num + den) / (2 * den);
    endfunction

    function automatic t_setting pick_setting(logic [CLK_W-1:0] clk_hz,
                                              logic [CLK_W-1:0] f_hz);
        longint clk;
        longint f;
        longint div16;
        longint wrap;
        longint fw;
        bit sat;
        t_setting r;
        clk = clk_hz;
        f = f_hz;
        sat = 0;
        if (f == 0) begin
            div16 = DIV_MAX;
            wrap = WMAX;
            sat = 1;
        end else if (clk <= WMAX * f) begin
            div16 = DIV_ONE;
            wrap = rnd_half_up(clk, f);
            if (wrap > WMAX) begin
                wrap = WMAX;
                sat = 1;
            end
        end else begin
            fw = f * WMAX;
            div16 = (16 * clk + fw - 1) / fw;
            if (div16 > DIV_MAX) begin
                div16 = DIV_MAX;
                sat = 1;
            end
            wrap = rnd_half_up(16 * clk, div16 * f);
            if (wrap > WMAX) begin
                wrap = WMAX;
                sat = 1;
            end
        end
        if (wrap < WRAP_MIN) wrap = WRAP_MIN;
        r.div = div16[DIV_W-1:0];
        r.wrap = wrap[WRAP_W-1:0];
        r.freq_q8 = FREQ_Q8_W'(rnd_half_up(clk * 4096, div16 * wrap));
        r.sat = sat;
        return r;
    endfunction

    task automatic send_word(logic [CLK_W-1:0] f, bit typed, t_setting want);
        int gap;
        t_setting next_want;
        gap = quiet ? 0 : $urandom_range(0, 13);
        if (gap > 0) begin
            i_valid <= 0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid <= 1;
        i_target_freq_hz <= f;
        next_want = typed ? want : pick_setting(clock_hz, f);
        pending_q = {pending_q, next_want};
        forever begin
            @(negedge i_clk);
            if (o_ready) begin
                @(posedge i_clk);
                break;
            end
        end
    endtask

    task automatic settle;
        i_valid <= 0;
        while (pending_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN) @(posedge i_clk);
    endtask

    task automatic write_clock(logic [CLK_W-1:0] c);
        i_cfg_we <= 1;
        i_cfg_data <= c;
        @(posedge i_clk);
        i_cfg_we <= 0;
        clock_hz = c;
    endtask

    function automatic logic [CLK_W-1:0] rand_freq(logic [CLK_W-1:0] c);
        longint knee;
        knee = c / WMAX + 1;
        case ($urandom_range(0, 5))
            0: return CLK_W'($urandom_range(0, 4000));
            1: return CLK_W'($urandom_range(1, knee * 20));
            2: return CLK_W'(knee + $urandom_range(0, 3) - 1);
            3: return CLK_W'($urandom_range(1, c + 1));
            default: return CLK_W'($urandom());
        endcase
    endfunction

    // output side with random stalls
    initial begin
        int stall;
        t_setting want;
        forever begin
            stall = quiet ? 0 : $urandom_range(0, 13);
            if (stall > 0) begin
                i_ready <= 0;
                repeat (stall) @(posedge i_clk);
            end
            i_ready <= 1;
            forever begin
                @(negedge i_clk);
                if (o_valid) break;
            end
            if (pending_q.size() == 0) begin
                $display("%0t: unexpected word div=%0d wrap=%0d", $time, o_divider_q4,
                         o_wrap_count);
                errors++;
            end else begin
                want = pending_q.pop_front();
                if (o_divider_q4 !== want.div) begin
                    $display("%0t: divider exp %0d got %0d", $time, want.div, o_divider_q4);
                    errors++;
                end
                if (o_wrap_count !== want.wrap) begin
                    $display("%0t: wrap exp %0d got %0d", $time, want.wrap, o_wrap_count);
                    errors++;
                end
                if (o_realized_freq_q8 !== want.freq_q8) begin
                    $display("%0t: freq_q8 exp %0d got %0d", $time, want.freq_q8,
                             o_realized_freq_q8);
                    errors++;
                end
                if (o_saturated !== want.sat) begin
                    $display("%0t: saturated exp %0b got %0b", $time, want.sat, o_saturated);
                    errors++;
                end
            end
            @(posedge i_clk);
        end
    end

    // watchdog on cycles with no word moving
    always @(negedge i_clk) begin
        if ((i_valid && o_ready) || (o_valid && i_ready) || i_cfg_we || !i_rst_n)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    initial begin
        t_row rows[N_ROWS];
        logic [CLK_W-1:0] clocks[5];
        rows = '{
            '{28'd0, 1'b1, '{12'd4095, 17'd65536, 30'd1908, 1'b1}},
            '{28'd125000000, 1'b1, '{12'd16, 17'd100, 30'd320000000, 1'b0}},
            '{28'hFFFFFFF, 1'b1, '{12'd16, 17'd100, 30'd320000000, 1'b0}},
            '{28'd1, 1'b1, '{12'd4095, 17'd65536, 30'd1908, 1'b1}},
            '{28'd1907, 1'b0, '0},
            '{28'd1908, 1'b0, '0},
            '{28'd1906, 1'b0, '0},
            '{28'd7, 1'b0, '0},
            '{28'd1250000, 1'b0, '0},
            '{28'd1262626, 1'b0, '0},
            '{28'd1240000, 1'b0, '0},
            '{28'd40000, 1'b0, '0},
            '{28'd20000, 1'b0, '0},
            '{28'd2000, 1'b0, '0},
            '{28'd1000, 1'b0, '0},
            '{28'd12345, 1'b0, '0},
            '{28'hAAAAAAA, 1'b0, '0},
            '{28'h5555555, 1'b0, '0}
        };
        clocks = '{28'd1, 28'd0, 28'hFFFFFFF, 28'd65536, 28'd0};
        clocks[4] = CLK_W'($urandom_range(1, 28'hFFFFFFF));

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);
        foreach (rows[k]) send_word(rows[k].freq, rows[k].typed, rows[k].want);
        settle();
        for (int p = 0; p < 6; p++) begin
            if (p > 0) write_clock(clocks[p-1]);
            else write_clock(CLK_RESET);
            for (int n = 0; n < 210; n++) begin
                if (n % 70 == 0) quiet = ($urandom_range(0, 3) == 0);
                send_word(rand_freq(clock_hz), 0, '0);
            end
            quiet = 0;
            settle();
        end
        if (errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end
endmodule

// ===== filelist.f =====
+incdir+sv
sv/pwmdw_pkg.sv
sv/pwmdw_divider.sv
sv/pwm_divider_wrap_calc_unit.sv
tb/pwm_divider_wrap_calc_unit_tb.sv
